FILE: design/slotalloc_pkg.sv
// Shared types and constants of the slot allocator.
package slotalloc_pkg;

  localparam int ROWS_DEF    = 256;
  localparam int ID_BITS_DEF = 32;
  localparam int FUNC_W      = 3;
  localparam int SLOT_W      = 8;
  localparam int ID_PORT_W   = 32;
  localparam int USED_W      = 9;

  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC = 3'd0,
    FN_FREE  = 3'd1,
    FN_READ  = 3'd2,
    FN_FIRST = 3'd3,
    FN_NEXT  = 3'd4,
    FN_PREV  = 3'd5
  } func_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ECHO,
    OP_ALLOC_NEW,
    OP_POP_READ,
    OP_ALLOC_POP,
    OP_OWNER_READ,
    OP_FREE_WR,
    OP_READ_RES,
    OP_SCAN_INIT,
    OP_SCAN_STEP
  } dp_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_POP,
    S_OWNER,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    dp_op_t op;
    logic   out_load;
  } ctl_cmd_t;

  typedef struct packed {
    func_t func;
    logic  stack_empty;
    logic  table_full;
    logic  slot_in_range;
    logic  scan_end;
  } dp_status_t;

endpackage

FILE: design/slot_allocator_with_free_stack.sv
// Slot allocator top level: a table of owner ids with a stack of freed slots.
// The input channel (in_valid, in_stall) carries func, owner_id and slot; the output
// channel (out_valid, out_stall) carries one result item per input item.
// Allocate pops the most recently freed slot, or else takes the slot at the
// high-water mark. Free clears a used slot and pushes it. The queries read one
// owner or scan the used slots for the first, next or previous one.
// One item is worked on at a time. Scans read the owner RAM once per cycle.
// The next item is accepted in the cycle after the result is loaded.
// Reset clears the high-water mark and the free stack count; the memories are not
// cleared, since an entry is read only after it has been written.
// The result sits in an output register. While the receiver stalls, the block still
// accepts the next item and works on it, but holds it until the waiting result is
// taken.
module slot_allocator_with_free_stack #(
  parameter int ROWS    = slotalloc_pkg::ROWS_DEF,
  parameter int ID_BITS = slotalloc_pkg::ID_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [slotalloc_pkg::FUNC_W-1:0]    func,
  input  logic [slotalloc_pkg::ID_PORT_W-1:0] owner_id,
  input  logic [slotalloc_pkg::SLOT_W-1:0]    slot,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [slotalloc_pkg::SLOT_W-1:0]    result_slot,
  output logic                                found,
  output logic [slotalloc_pkg::ID_PORT_W-1:0] owner_out,
  output logic [slotalloc_pkg::USED_W-1:0]    used_rows
);
  import slotalloc_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  slotalloc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd)
  );

  slotalloc_dp #(
    .ROWS   (ROWS),
    .ID_BITS(ID_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .func       (func),
    .owner_id   (owner_id),
    .slot       (slot),
    .cmd        (cmd),
    .status     (status),
    .result_slot(result_slot),
    .found      (found),
    .owner_out  (owner_out),
    .used_rows  (used_rows)
  );

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("A waiting result was overwritten.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("A second item was accepted before the first was done.");

  a_no_alloc_when_full: assert property (@(posedge clk) disable iff (rst)
    status.table_full |-> (cmd.op != OP_ALLOC_NEW))
    else $error("Allocation beyond the last slot.");
`endif

endmodule

FILE: design/slotalloc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module slotalloc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/slotalloc_ctrl.sv
// Controller state machine of the slot allocator.
module slotalloc_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  logic                     out_stall,
  input  slotalloc_pkg::dp_status_t status,
  output slotalloc_pkg::ctl_cmd_t   cmd
);
  import slotalloc_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (status.func)
          FN_ALLOC: state_next = status.stack_empty ? S_DONE : S_POP;
          FN_FREE, FN_READ: state_next = status.slot_in_range ? S_OWNER : S_DONE;
          FN_FIRST, FN_NEXT, FN_PREV: state_next = S_SCAN;
          default: state_next = S_DONE;
        endcase
      end
      S_POP:   state_next = S_DONE;
      S_OWNER: state_next = S_DONE;
      S_SCAN: begin
        if (status.scan_end) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op       = OP_NONE;
    cmd.out_load = 1'b0;
    in_stall     = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) cmd.op = OP_LOAD;
      end
      S_DECODE: begin
        case (status.func)
          FN_ALLOC: begin
            if (!status.stack_empty) begin
              cmd.op = OP_POP_READ;
            end else if (!status.table_full) begin
              cmd.op = OP_ALLOC_NEW;
            end
          end
          FN_FREE, FN_READ: cmd.op = status.slot_in_range ? OP_OWNER_READ : OP_ECHO;
          FN_FIRST, FN_NEXT, FN_PREV: cmd.op = OP_SCAN_INIT;
          default: cmd.op = OP_NONE;
        endcase
      end
      S_POP:   cmd.op = OP_ALLOC_POP;
      S_OWNER: cmd.op = (status.func == FN_FREE) ? OP_FREE_WR : OP_READ_RES;
      S_SCAN:  cmd.op = OP_SCAN_STEP;
      S_DONE:  cmd.out_load = out_free;
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

FILE: design/slotalloc_dp.sv
// Datapath of the slot allocator: owner table, free stack, scan pointer and result registers.
module slotalloc_dp #(
  parameter int ROWS    = slotalloc_pkg::ROWS_DEF,
  parameter int ID_BITS = slotalloc_pkg::ID_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [slotalloc_pkg::FUNC_W-1:0]       func,
  input  logic [slotalloc_pkg::ID_PORT_W-1:0]    owner_id,
  input  logic [slotalloc_pkg::SLOT_W-1:0]       slot,
  input  slotalloc_pkg::ctl_cmd_t                cmd,
  output slotalloc_pkg::dp_status_t              status,
  output logic [slotalloc_pkg::SLOT_W-1:0]       result_slot,
  output logic                                   found,
  output logic [slotalloc_pkg::ID_PORT_W-1:0]    owner_out,
  output logic [slotalloc_pkg::USED_W-1:0]       used_rows
);
  import slotalloc_pkg::*;

  localparam int AW = $clog2(ROWS);
  localparam int CW = AW + 1;
  localparam int XW = (CW > SLOT_W + 1) ? CW : SLOT_W + 1;

  logic [FUNC_W-1:0]  func_q;
  logic [ID_BITS-1:0] id_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [CW-1:0]      hw;
  logic [CW-1:0]      fc;
  logic [AW-1:0]      ptr;
  logic [AW-1:0]      chk_ptr;
  logic               chk_valid;
  logic [CW-1:0]      remain;
  logic               scan_up;
  logic [XW-1:0]      res_slot;
  logic               res_found;
  logic [ID_BITS-1:0] res_owner;

  logic [XW-1:0]      slot_x;
  logic [XW-1:0]      hw_x;
  logic [AW-1:0]      slot_addr;
  logic               in_range;
  logic               own_nz;
  logic               hit;
  logic               push_ok;

  logic               o_we;
  logic [AW-1:0]      o_waddr;
  logic [ID_BITS-1:0] o_wdata;
  logic               o_re;
  logic [AW-1:0]      o_raddr;
  logic [ID_BITS-1:0] own_rdata;
  logic               s_we;
  logic [AW-1:0]      s_waddr;
  logic               s_re;
  logic [AW-1:0]      s_raddr;
  logic [AW-1:0]      stk_rdata;

  assign slot_x    = XW'(slot_q);
  assign hw_x      = XW'(hw);
  assign slot_addr = AW'(slot_x);
  assign in_range  = slot_x < hw_x;
  assign own_nz    = own_rdata != '0;
  assign hit       = chk_valid && own_nz;
  assign push_ok   = fc < CW'(ROWS);

  assign status.func          = func_t'(func_q);
  assign status.stack_empty   = fc == '0;
  assign status.table_full    = hw == CW'(ROWS);
  assign status.slot_in_range = in_range;
  assign status.scan_end      = hit || (remain == '0);

  always_comb begin
    o_we    = 1'b0;
    o_waddr = slot_addr;
    o_wdata = '0;
    o_re    = 1'b0;
    o_raddr = slot_addr;
    s_we    = 1'b0;
    s_waddr = AW'(fc);
    s_re    = 1'b0;
    s_raddr = AW'(fc - 1'b1);
    case (cmd.op)
      OP_ALLOC_NEW: begin
        o_we    = 1'b1;
        o_waddr = AW'(hw);
        o_wdata = id_q;
      end
      OP_ALLOC_POP: begin
        o_we    = 1'b1;
        o_waddr = stk_rdata;
        o_wdata = id_q;
      end
      OP_POP_READ:   s_re = 1'b1;
      OP_OWNER_READ: o_re = 1'b1;
      OP_FREE_WR: begin
        o_we = own_nz;
        s_we = own_nz && push_ok;
      end
      OP_SCAN_STEP: begin
        o_re    = remain != '0;
        o_raddr = ptr;
      end
      default: o_we = 1'b0;
    endcase
  end

  slotalloc_ram #(
    .WIDTH(ID_BITS),
    .DEPTH(ROWS)
  ) u_owner_ram (
    .clk  (clk),
    .we   (o_we),
    .waddr(o_waddr),
    .wdata(o_wdata),
    .re   (o_re),
    .raddr(o_raddr),
    .rdata(own_rdata)
  );

  slotalloc_ram #(
    .WIDTH(AW),
    .DEPTH(ROWS)
  ) u_stack_ram (
    .clk  (clk),
    .we   (s_we),
    .waddr(s_waddr),
    .wdata(slot_addr),
    .re   (s_re),
    .raddr(s_raddr),
    .rdata(stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hw        <= '0;
      fc        <= '0;
      chk_valid <= 1'b0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          func_q    <= func;
          id_q      <= ID_BITS'(owner_id);
          slot_q    <= slot;
          res_slot  <= '0;
          res_found <= 1'b0;
          res_owner <= '0;
        end
        OP_ECHO: res_slot <= slot_x;
        OP_ALLOC_NEW: begin
          res_slot  <= hw_x;
          res_found <= 1'b1;
          res_owner <= id_q;
          hw        <= hw + 1'b1;
        end
        OP_POP_READ: fc <= fc - 1'b1;
        OP_ALLOC_POP: begin
          res_slot  <= XW'(stk_rdata);
          res_found <= 1'b1;
          res_owner <= id_q;
        end
        OP_FREE_WR: begin
          res_slot <= slot_x;
          if (own_nz) begin
            res_found <= 1'b1;
            res_owner <= own_rdata;
            if (push_ok) fc <= fc + 1'b1;
          end
        end
        OP_READ_RES: begin
          res_slot  <= slot_x;
          res_found <= own_nz;
          res_owner <= own_rdata;
        end
        OP_SCAN_INIT: begin
          chk_valid <= 1'b0;
          case (func_t'(func_q))
            FN_FIRST: begin
              ptr     <= '0;
              remain  <= hw;
              scan_up <= 1'b1;
            end
            FN_NEXT: begin
              ptr     <= AW'(slot_x + 1'b1);
              scan_up <= 1'b1;
              remain  <= ((slot_x + 1'b1) < hw_x) ? CW'(hw_x - slot_x - 1'b1) : '0;
            end
            FN_PREV: begin
              ptr     <= AW'(slot_x - 1'b1);
              scan_up <= 1'b0;
              remain  <= ((slot_q != '0) && in_range) ? CW'(slot_x) : '0;
            end
            default: remain <= '0;
          endcase
        end
        OP_SCAN_STEP: begin
          if (hit) begin
            res_slot  <= XW'(chk_ptr);
            res_found <= 1'b1;
            res_owner <= own_rdata;
          end
          if (remain != '0) begin
            chk_ptr   <= ptr;
            chk_valid <= 1'b1;
            ptr       <= scan_up ? ptr + 1'b1 : ptr - 1'b1;
            remain    <= remain - 1'b1;
          end else begin
            chk_valid <= 1'b0;
          end
        end
        default: chk_valid <= chk_valid;
      endcase
      if (cmd.out_load) begin
        result_slot <= SLOT_W'(res_slot);
        found       <= res_found;
        owner_out   <= ID_PORT_W'(res_owner);
        used_rows   <= USED_W'(hw);
      end
    end
  end

endmodule
